// ----- hdl/esd_pkg.sv -----
// ----------------------------------------------------------------------------
// esd_pkg
// Types, character codes and the hex digit helper of the escape decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX1  = 2'd2,
    MODE_HEX2  = 2'd3
  } esd_mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BEL       = 8'h07;
  localparam logic [7:0] CH_BS        = 8'h08;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } esd_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       end_of_string;
  } esd_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } esd_hex_t;

  function automatic esd_hex_t hex_digit(input logic [7:0] c);
    esd_hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // letters a-f and A-F share the low three bits
      h.ok  = 1'b1;
      h.val = 4'd9 + {1'b0, c[2:0]};
    end
    return h;
  endfunction

endpackage

// ----- hdl/esd_ifs.sv -----
// ----------------------------------------------------------------------------
// esd channel interfaces
// Valid/ready channels for raw bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       end_of_string;

  modport source (output valid, output out_valid, output out_byte,
                  output end_of_string, input ready);
  modport sink   (input valid, input out_valid, input out_byte,
                  input end_of_string, output ready);
endinterface

// ----- hdl/esd_in_stage.sv -----
// ----------------------------------------------------------------------------
// esd_in_stage
// Input register: captures one raw byte item and holds it for the decoder.
// ----------------------------------------------------------------------------
module esd_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  esd_in_if.sink             in_ch,
  input  logic               take,
  output logic               item_vld,
  output esd_pkg::esd_item_t item
);
  import esd_pkg::*;

  logic      vld_r;
  logic      vld_nxt;
  esd_item_t item_r;
  logic      accept;

  assign in_ch.ready = !vld_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.in_byte <= in_ch.in_byte;
      item_r.in_last <= in_ch.in_last;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ----- hdl/esd_core.sv -----
// ----------------------------------------------------------------------------
// esd_core
// Escape decode logic with the mode register and the hex accumulator.
// ----------------------------------------------------------------------------
module esd_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  esd_pkg::esd_item_t item,
  output esd_pkg::esd_res_t  res
);
  import esd_pkg::*;

  esd_mode_t  mode_r;
  esd_mode_t  mode_nxt;
  logic [7:0] acc_r;
  logic [7:0] acc_nxt;
  esd_hex_t   hex;
  logic       vld;
  logic [7:0] ob;

  assign hex = hex_digit(item.in_byte);

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    vld      = 1'b0;
    ob       = 8'd0;
    case (mode_r)
      MODE_PLAIN: begin
        if (item.in_byte == CH_BACKSLASH && !item.in_last) begin
          mode_nxt = MODE_ESC;
        end else begin
          vld = 1'b1;
          ob  = item.in_byte;
        end
      end
      MODE_ESC: begin
        mode_nxt = MODE_PLAIN;
        case (item.in_byte)
          CH_BACKSLASH: begin vld = 1'b1; ob = CH_BACKSLASH; end
          CH_QUOTE:     begin vld = 1'b1; ob = CH_QUOTE;     end
          CH_N:         begin vld = 1'b1; ob = CH_LF;        end
          CH_R:         begin vld = 1'b1; ob = CH_CR;        end
          CH_T:         begin vld = 1'b1; ob = CH_TAB;       end
          CH_A:         begin vld = 1'b1; ob = CH_BEL;       end
          CH_B:         begin vld = 1'b1; ob = CH_BS;        end
          CH_X: begin
            acc_nxt = 8'd0;
            if (item.in_last) begin
              vld = 1'b1;
            end else begin
              mode_nxt = MODE_HEX1;
            end
          end
          default: begin
            // unknown escape letter, both bytes dropped
            vld = 1'b0;
          end
        endcase
      end
      MODE_HEX1: begin
        if (hex.ok) begin
          acc_nxt = {acc_r[3:0], hex.val};
        end
        if (item.in_last) begin
          vld = 1'b1;
          ob  = acc_nxt;
        end else begin
          mode_nxt = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        if (hex.ok) begin
          acc_nxt = {acc_r[3:0], hex.val};
        end
        vld      = 1'b1;
        ob       = acc_nxt;
        mode_nxt = MODE_PLAIN;
      end
      default: begin
        mode_nxt = MODE_PLAIN;
      end
    endcase
    if (item.in_last) begin
      mode_nxt = MODE_PLAIN;
      acc_nxt  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r  <= 8'd0;
    end else if (step) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

  assign res.out_valid     = vld;
  assign res.out_byte      = ob;
  assign res.end_of_string = item.in_last;

endmodule

// ----- hdl/esd_out_stage.sv -----
// ----------------------------------------------------------------------------
// esd_out_stage
// Result register: holds one decoded item until the receiver takes it.
// ----------------------------------------------------------------------------
module esd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  esd_pkg::esd_res_t res,
  output logic              space,
  esd_out_if.source         out_ch
);
  import esd_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  esd_res_t res_r;

  assign space = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = vld_r;
  assign out_ch.out_valid     = res_r.out_valid;
  assign out_ch.out_byte      = res_r.out_byte;
  assign out_ch.end_of_string = res_r.end_of_string;

endmodule

// ----- hdl/escape_sequence_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// escape_sequence_decoder_unit
// Streaming decoder for C-style escaped strings, one byte per item.
// ----------------------------------------------------------------------------
// in_ch carries one raw byte (in_byte) and a last-byte flag (in_last).
// out_ch returns exactly one result item for every input item: out_valid
// says whether out_byte holds a decoded byte (out_byte is zero otherwise),
// end_of_string repeats in_last of the matching input.
// Escapes handled: backslash, quote, n, r, t, a, b and x with two hex digits.
// A string that ends inside a hex escape emits the value gathered so far.
// Path: an accepted item waits in the input register, then is decoded into
// the result register, which presents it on out_ch.
// Throughput: one item per cycle while the receiver takes results; the only
// per-item loop is the update of the mode register and the hex accumulator.
// Reset: synchronous, active low; both registers empty, plain mode, zero
// accumulator.
// When the receiver stalls the result register holds, the input register
// keeps one more item, and in_ch.ready drops only when both are full.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_unit (
  input  logic      clk,
  input  logic      rst_n,
  esd_in_if.sink    in_ch,
  esd_out_if.source out_ch
);
  import esd_pkg::*;

  logic      item_vld;
  esd_item_t item;
  esd_res_t  res;
  logic      space;
  logic      step;

  // an item moves from the input register into the result register
  assign step = item_vld && space;

  esd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (step),
    .item_vld (item_vld),
    .item     (item)
  );

  esd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .res   (res)
  );

  esd_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (step),
    .res    (res),
    .space  (space),
    .out_ch (out_ch)
  );

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_ch.valid)
    else $error("decoded item not registered at output");

  a_accept_fills_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> item_vld)
    else $error("accepted item lost before decode");

  a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.out_valid |-> out_ch.out_byte == 8'd0)
    else $error("empty result carries a nonzero byte");

  a_last_carried: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_ch.end_of_string == $past(item.in_last))
    else $error("end of string flag not carried");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives escaped byte strings into escape_sequence_decoder_unit, decodes
// each accepted item in a local model of the decoder and compares every
// returned result field by field, in order, under random idle on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import esd_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1400;

  logic clk;
  logic rst_n;

  esd_in_if  in_ch ();
  esd_out_if out_ch ();

  escape_sequence_decoder_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the decoder state
  esd_mode_t  dec_mode;
  logic [7:0] dec_accum;

  esd_res_t   pending_decodes[$];
  logic [7:0] str_bytes[$];
  int         bytes_sent;
  int         results_seen;
  int         mismatch_count;
  int         idle_cycles;
  int         in_gap_max;
  int         out_stall_max;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // advances the local decoder by one byte and returns the result it owes
  function automatic esd_res_t decode_byte(input logic [7:0] b, input logic last);
    esd_res_t r;
    int       d;
    r.out_valid     = 1'b0;
    r.out_byte      = 8'h00;
    r.end_of_string = last;
    case (dec_mode)
      MODE_PLAIN: begin
        if (b == CH_BACKSLASH && !last) begin
          dec_mode = MODE_ESC;
        end else begin
          r.out_valid = 1'b1;
          r.out_byte  = b;
        end
      end
      MODE_ESC: begin
        dec_mode    = MODE_PLAIN;
        r.out_valid = 1'b1;
        case (b)
          CH_BACKSLASH: r.out_byte = CH_BACKSLASH;
          CH_QUOTE:     r.out_byte = CH_QUOTE;
          CH_N:         r.out_byte = CH_LF;
          CH_R:         r.out_byte = CH_CR;
          CH_T:         r.out_byte = CH_TAB;
          CH_A:         r.out_byte = CH_BEL;
          CH_B:         r.out_byte = CH_BS;
          CH_X: begin
            dec_accum = 8'h00;
            // \x cut off right here gives a zero byte
            if (!last) begin
              r.out_valid = 1'b0;
              dec_mode    = MODE_HEX1;
            end
          end
          default: r.out_valid = 1'b0;
        endcase
      end
      MODE_HEX1: begin
        d = hex_nibble(b);
        if (d >= 0) dec_accum = {dec_accum[3:0], d[3:0]};
        if (last) begin
          r.out_valid = 1'b1;
          r.out_byte  = dec_accum;
        end else begin
          dec_mode = MODE_HEX2;
        end
      end
      default: begin
        d = hex_nibble(b);
        if (d >= 0) dec_accum = {dec_accum[3:0], d[3:0]};
        r.out_valid = 1'b1;
        r.out_byte  = dec_accum;
        dec_mode    = MODE_PLAIN;
      end
    endcase
    if (last) begin
      dec_mode  = MODE_PLAIN;
      dec_accum = 8'h00;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: %s mismatch at result %0d: got %0h, expected %0h",
             what, results_seen, got, want);
    mismatch_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_decodes.push_back(decode_byte(b, last));
    bytes_sent++;
  endtask

  task automatic send_queued();
    foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
    str_bytes.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] simple_escape_letter(input int idx);
    case (idx)
      0:       return CH_BACKSLASH;
      1:       return CH_QUOTE;
      2:       return CH_N;
      3:       return CH_R;
      4:       return CH_T;
      5:       return CH_A;
      default: return CH_B;
    endcase
  endfunction

  function automatic logic [7:0] rand_hex_char();
    case ($urandom_range(0, 2))
      0:       return 8'("0" + $urandom_range(0, 9));
      1:       return 8'("a" + $urandom_range(0, 5));
      default: return 8'("A" + $urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] rand_unknown_letter();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_BACKSLASH || c == CH_QUOTE || c == CH_N || c == CH_R ||
           c == CH_T || c == CH_A || c == CH_B || c == CH_X);
    return c;
  endfunction

  // one piece of an escaped string (plain byte, simple, hex or unknown escape), or now and then a raw byte
  task automatic append_token();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      str_bytes.push_back(8'($urandom_range(0, CH_BACKSLASH - 1)));
      if ($urandom_range(0, 1)) str_bytes[$] = 8'($urandom_range(CH_BACKSLASH + 1, 255));
    end else if (kind < 60) begin
      str_bytes.push_back(CH_BACKSLASH);
      str_bytes.push_back(simple_escape_letter($urandom_range(0, 6)));
    end else if (kind < 82) begin
      str_bytes.push_back(CH_BACKSLASH);
      str_bytes.push_back(CH_X);
      repeat (2) begin
        if ($urandom_range(0, 9) == 0) str_bytes.push_back(rand_non_hex());
        else str_bytes.push_back(rand_hex_char());
      end
    end else if (kind < 90) begin
      str_bytes.push_back(CH_BACKSLASH);
      str_bytes.push_back(rand_unknown_letter());
    end else begin
      str_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_string();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw bytes with string ends scattered anywhere
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), i == n - 1 || $urandom_range(0, 3) == 0);
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) append_token();
      // cut some strings short so they can end inside an escape
      if ($urandom_range(0, 4) == 0)
        while (str_bytes.size() > 1 && $urandom_range(0, 2) != 0) void'(str_bytes.pop_back());
      send_queued();
    end
  endtask

  task automatic test_plain_bytes();
    str_bytes.push_back(8'h00);
    str_bytes.push_back(8'hFF);
    send_queued();
  endtask

  task automatic test_simple_escapes();
    for (int i = 0; i < 7; i++) begin
      str_bytes.push_back(CH_BACKSLASH);
      str_bytes.push_back(simple_escape_letter(i));
    end
    send_queued();
  endtask

  task automatic test_hex_escape();
    send_text("\\xfF");
  endtask

  task automatic test_unknown_escape();
    send_text("\\q");
  endtask

  task automatic test_backslash_at_end();
    send_text("\\");
  endtask

  task automatic test_cut_hex();
    // non-hex digit slot that also ends the string, then \x at the very end
    send_text("\\xz");
    send_text("\\x");
  endtask

  task automatic test_back_to_back(input int count);
    int stop_at;
    stop_at       = bytes_sent + count;
    in_gap_max    = 0;
    out_stall_max = 0;
    while (bytes_sent < stop_at) send_random_string();
    in_gap_max    = 6;
    out_stall_max = 6;
  endtask

  task automatic test_random_strings(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_random_string();
  endtask

  // receiver: random stall before each result, then check it
  initial begin
    int       stall;
    esd_res_t want;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected result", out_ch.out_byte, 0);
      end else begin
        want = pending_decodes.pop_front();
        if (out_ch.out_valid !== want.out_valid)
          report_mismatch("out_valid", out_ch.out_valid, want.out_valid);
        if (out_ch.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
        if (out_ch.end_of_string !== want.end_of_string)
          report_mismatch("end_of_string", out_ch.end_of_string, want.end_of_string);
      end
      results_seen++;
    end
  end

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.in_byte  <= 8'h00;
    in_ch.in_last  <= 1'b0;
    dec_mode       = MODE_PLAIN;
    dec_accum      = 8'h00;
    bytes_sent     = 0;
    results_seen   = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    in_gap_max     = 6;
    out_stall_max  = 6;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_plain_bytes();
    test_simple_escapes();
    test_hex_escape();
    test_unknown_escape();
    test_backslash_at_end();
    test_cut_hex();
    test_back_to_back(200);
    test_random_strings(RANDOM_ITEMS - 200);

    in_ch.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/esd_pkg.sv
hdl/esd_ifs.sv
hdl/esd_in_stage.sv
hdl/esd_core.sv
hdl/esd_out_stage.sv
hdl/escape_sequence_decoder_unit.sv
tb/sv/tb_top.sv
